@@ design/env_sensor_compensation_top_assert.svh @@
// Assertion macros for the environmental sensor compensation block, used by its queue.
`ifndef ENV_SENSOR_COMPENSATION_TOP_ASSERT_SVH
`define ENV_SENSOR_COMPENSATION_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ESC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property failed");
// Condition must never be seen at a clock edge outside reset.
`define ESC_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define ESC_ASSERT(lbl, clk, rst_n, prop)
`define ESC_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ design/esc_pkg.sv @@
// Types and constants shared by the sensor compensation modules.
`timescale 1ns / 1ps
package esc_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_TEMP   = 3'd0;
  localparam logic [2:0] CFG_P_LOW  = 3'd1;
  localparam logic [2:0] CFG_P_MID  = 3'd2;
  localparam logic [2:0] CFG_P_NINE = 3'd3;
  localparam logic [2:0] CFG_HUM    = 3'd4;
  localparam logic [2:0] CFG_OFFSET = 3'd5;

  // Pressure status codes.
  localparam logic [1:0] PSTAT_OK   = 2'd0;
  localparam logic [1:0] PSTAT_DIS  = 2'd1;
  localparam logic [1:0] PSTAT_DIV0 = 2'd2;

  localparam logic [23:0] PRESS_DIS_CODE = 24'h800000;
  localparam logic [15:0] HUM_DIS_CODE   = 16'h8000;
  localparam logic [31:0] HUM_MAX        = 32'd419430400;

  // Quotient bits resolved by the divider, one per stage.
  localparam int DIV_W = 64;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [31:0] offset;
  } tcoef_t;

  typedef struct packed {
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } pcoef_t;

  typedef struct packed {
    logic [7:0]  h1;
    logic [15:0] h2;
    logic [7:0]  h3;
    logic [11:0] h4;
    logic [11:0] h5;
    logic [7:0]  h6;
  } hcoef_t;

  // One classified reading as it waits between front and back.
  typedef struct packed {
    logic [31:0] fine;
    logic [23:0] temp_centi;
    logic [23:0] raw_pressure;
    logic [15:0] raw_humidity;
    logic        press_dis;
    logic        hum_dis;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } q_wr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Side data that rides along the divider pipeline.
  typedef struct packed {
    logic        q_neg;
    logic [1:0]  status;
    logic [23:0] temp_centi;
    logic [16:0] humidity;
    logic        hum_dis;
  } div_tag_t;

endpackage

@@ design/env_sensor_compensation_top.sv @@
// Top level of the environmental sensor compensation block.
//
//   Channel  | Direction | Contents of one request
//   ---------+-----------+------------------------------------------------
//   in_      | input     | raw temperature, pressure and humidity words
//   out_     | output    | compensated temperature, pressure, humidity
//   cfg_     | input     | calibration words and fine temperature offset
//
// One request is taken per cycle and one result leaves per cycle when the
// output side keeps taking them. On its way to the output register a
// reading spends most time in the 64-stage pipelined divider in the
// pressure path, one quotient bit per stage.
// Reset is synchronous and active low; it empties all pipelines and clears
// the calibration registers to zero.
// An output stall freezes the back pipeline; the queue then fills, and
// only when it is full and the last front stage is valid does in_tready drop.
`timescale 1ns / 1ps
module env_sensor_compensation_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // raw_temperature, raw_pressure, raw_humidity
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // temperature_centi, pressure_q24_8,
                                  // humidity_q7_10, zero fill
  output logic [2:0]  out_tuser,  // pressure_status, humidity_disabled
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [63:0] cfg_wdata
);

  // Calibration registers; write only while the block is idle (the block itself does not enforce this).
  logic [47:0] temp_coeffs_r;
  logic [63:0] p_low_r, p_mid_r, hum_coeffs_r;
  logic [15:0] p_nine_r;
  logic [31:0] offset_r;

  esc_pkg::tcoef_t  tcoef;
  esc_pkg::pcoef_t  pcoef;
  esc_pkg::hcoef_t  hcoef;
  esc_pkg::q_wr_t   qwr;
  esc_pkg::q_stat_t qstat;
  esc_pkg::item_t   qitem;
  logic             pop;

  logic [23:0] temp_centi;
  logic [31:0] pressure;
  logic [1:0]  pstat;
  logic [16:0] humidity;
  logic        hum_dis;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coeffs_r <= '0;
      p_low_r       <= '0;
      p_mid_r       <= '0;
      p_nine_r      <= '0;
      hum_coeffs_r  <= '0;
      offset_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        esc_pkg::CFG_TEMP:   temp_coeffs_r <= cfg_wdata[47:0];
        esc_pkg::CFG_P_LOW:  p_low_r       <= cfg_wdata;
        esc_pkg::CFG_P_MID:  p_mid_r       <= cfg_wdata;
        esc_pkg::CFG_P_NINE: p_nine_r      <= cfg_wdata[15:0];
        esc_pkg::CFG_HUM:    hum_coeffs_r  <= cfg_wdata;
        esc_pkg::CFG_OFFSET: offset_r      <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // Unpack the calibration words into named coefficients.
  assign tcoef = '{t1: temp_coeffs_r[15:0], t2: temp_coeffs_r[31:16],
                   t3: temp_coeffs_r[47:32], offset: offset_r};
  assign pcoef = '{p1: p_low_r[15:0], p2: p_low_r[31:16], p3: p_low_r[47:32],
                   p4: p_low_r[63:48], p5: p_mid_r[15:0], p6: p_mid_r[31:16],
                   p7: p_mid_r[47:32], p8: p_mid_r[63:48], p9: p_nine_r};
  assign hcoef = '{h1: hum_coeffs_r[7:0], h2: hum_coeffs_r[23:8],
                   h3: hum_coeffs_r[31:24], h4: hum_coeffs_r[43:32],
                   h5: hum_coeffs_r[55:44], h6: hum_coeffs_r[63:56]};

  // The front end works out fine temperature and the temperature result,
  // and flags disabled pressure and humidity readings.
  esc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .raw_t   (in_tdata[23:0]),
    .raw_p   (in_tdata[47:24]),
    .raw_h   (in_tdata[63:48]),
    .tcoef   (tcoef),
    .qstat   (qstat),
    .qwr     (qwr)
  );

  esc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_i  (qwr),
    .pop_i (pop),
    .rd_o  (qitem),
    .stat_o(qstat)
  );

  // The back end runs pressure (with its divider) and humidity side by side
  // and ends in the output register.
  esc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .item      (qitem),
    .pop       (pop),
    .pcoef     (pcoef),
    .hcoef     (hcoef),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .temp_centi(temp_centi),
    .pressure  (pressure),
    .pstat     (pstat),
    .humidity  (humidity),
    .hum_dis   (hum_dis)
  );

  assign out_tdata = {7'd0, humidity, pressure, temp_centi};
  assign out_tuser = {hum_dis, pstat};

endmodule

@@ design/esc_front.sv @@
// Front end: accepts raw readings, classifies them and forms fine temperature.
`timescale 1ns / 1ps
module esc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [23:0]      raw_t,
  input  logic [23:0]      raw_p,
  input  logic [15:0]      raw_h,
  input  esc_pkg::tcoef_t  tcoef,
  input  esc_pkg::q_stat_t qstat,
  output esc_pkg::q_wr_t   qwr
);

  typedef struct packed {
    logic [23:0] rawp;
    logic [15:0] rawh;
    logic        pdis;
    logic        hdis;
  } side_t;

  logic              fe;
  logic [4:0]        v_r;
  side_t             sd_r [5];
  logic signed [17:0] d1_r;
  logic signed [16:0] d2_r;
  logic signed [33:0] tv1p_r, dd_r;
  logic signed [22:0] tv1_r;
  logic signed [38:0] tv2p_r;
  logic signed [31:0] fine_r, fine5_r;
  logic [23:0]        tc_r;

  logic signed [17:0] d1_nxt;
  logic signed [16:0] d2_nxt;
  logic signed [33:0] tv1_sh;
  logic signed [24:0] tv2_sh;
  logic signed [33:0] fsum;
  logic signed [31:0] fine_nxt;
  logic signed [35:0] t5;
  logic signed [27:0] t5_sh;
  logic [23:0]        tc_nxt;

  assign fe       = !v_r[4] || !qstat.full;
  assign in_ready = fe;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (fe) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  always_comb begin
    d1_nxt   = $signed({1'b0, raw_t[23:7]}) - $signed({1'b0, tcoef.t1, 1'b0});
    d2_nxt   = $signed({1'b0, raw_t[23:8]}) - $signed({1'b0, tcoef.t1});
    tv1_sh   = tv1p_r >>> 11;
    tv2_sh   = 25'(tv2p_r >>> 14);
    fsum     = 34'(tv1_r) + 34'(tv2_sh) + 34'($signed(tcoef.offset));
    if (fsum > 34'sd2147483647) begin
      fine_nxt = 32'sh7FFFFFFF;
    end else if (fsum < -34'sd2147483648) begin
      fine_nxt = 32'sh80000000;
    end else begin
      fine_nxt = fsum[31:0];
    end
    t5    = (36'(fine_r) <<< 2) + 36'(fine_r) + 36'sd128;
    t5_sh = 28'(t5 >>> 8);
    if (t5_sh > 28'sd8388607) begin
      tc_nxt = 24'h7FFFFF;
    end else if (t5_sh < -28'sd8388608) begin
      tc_nxt = 24'h800000;
    end else begin
      tc_nxt = t5_sh[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      sd_r[0] <= '{rawp: raw_p, rawh: raw_h,
                   pdis: (raw_p == esc_pkg::PRESS_DIS_CODE),
                   hdis: (raw_h == esc_pkg::HUM_DIS_CODE)};
      for (int k = 1; k < 5; k++) begin
        sd_r[k] <= sd_r[k-1];
      end
      d1_r    <= d1_nxt;
      d2_r    <= d2_nxt;
      tv1p_r  <= d1_r * $signed(tcoef.t2);
      dd_r    <= d2_r * d2_r;
      tv1_r   <= tv1_sh[22:0];
      tv2p_r  <= $signed({1'b0, dd_r[33:12]}) * $signed(tcoef.t3);
      fine_r  <= fine_nxt;
      fine5_r <= fine_r;
      tc_r    <= tc_nxt;
    end
  end

  assign qwr.push = v_r[4] && !qstat.full;
  assign qwr.item = '{fine: fine5_r, temp_centi: tc_r, raw_pressure: sd_r[4].rawp,
                      raw_humidity: sd_r[4].rawh, press_dis: sd_r[4].pdis,
                      hum_dis: sd_r[4].hdis};

endmodule

@@ design/esc_queue.sv @@
// Short queue between the front end and the compensation back end.
`timescale 1ns / 1ps
`include "env_sensor_compensation_top_assert.svh"
module esc_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  esc_pkg::q_wr_t   wr_i,
  input  logic             pop_i,
  output esc_pkg::item_t   rd_o,
  output esc_pkg::q_stat_t stat_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  esc_pkg::item_t mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;
  logic           full, empty;

  assign full   = (count_r == FULL_CNT);
  assign empty  = (count_r == '0);
  assign stat_o = '{full: full, empty: empty};
  assign rd_o   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_i.push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (wr_i.push && !pop_i) begin
        count_r <= count_r + 1'b1;
      end else if (pop_i && !wr_i.push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_i.push) begin
      mem_r[wr_ptr_r] <= wr_i.item;
    end
  end

  `ESC_NEVER(a_push_full, clk, rst_n, wr_i.push && full)
  `ESC_NEVER(a_pop_empty, clk, rst_n, pop_i && empty)
  `ESC_ASSERT(a_count_bound, clk, rst_n, count_r <= FULL_CNT)
  `ESC_ASSERT(a_push_fills, clk, rst_n, (wr_i.push && !pop_i) |=> !empty)

endmodule

@@ design/esc_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with side data.
`timescale 1ns / 1ps
module esc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [63:0]         dividend,
  input  logic [63:0]         divisor,
  input  esc_pkg::div_tag_t   in_tag,
  output logic                out_valid,
  output logic [63:0]         quotient,
  output esc_pkg::div_tag_t   out_tag
);

  localparam int N = esc_pkg::DIV_W;

  logic [N-1:0]      v_r;
  logic [N-1:0]      rem_r [N];
  logic [N-1:0]      num_r [N];
  logic [N-1:0]      quo_r [N];
  logic [N-1:0]      den_r [N];
  esc_pkg::div_tag_t tag_r [N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[N-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [N-1:0]      rem_in, num_in, quo_in, den_in, shifted;
    logic [N:0]        diff;
    esc_pkg::div_tag_t tag_in;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = dividend;
      assign quo_in = '0;
      assign den_in = divisor;
      assign tag_in = in_tag;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign num_in = num_r[k-1];
      assign quo_in = quo_r[k-1];
      assign den_in = den_r[k-1];
      assign tag_in = tag_r[k-1];
    end

    // The partial remainder stays below the divisor, so its top bit is free.
    assign shifted = {rem_in[N-2:0], num_in[N-1]};
    assign diff    = {1'b0, shifted} - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= diff[N] ? shifted : diff[N-1:0];
        quo_r[k] <= {quo_in[N-2:0], ~diff[N]};
        num_r[k] <= {num_in[N-2:0], 1'b0};
        den_r[k] <= den_in;
        tag_r[k] <= tag_in;
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign quotient  = quo_r[N-1];
  assign out_tag   = tag_r[N-1];

endmodule

@@ design/esc_back.sv @@
// Back end: pressure and humidity compensation pipelines and the output register.
`timescale 1ns / 1ps
module esc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  esc_pkg::q_stat_t qstat,
  input  esc_pkg::item_t   item,
  output logic             pop,
  input  esc_pkg::pcoef_t  pcoef,
  input  esc_pkg::hcoef_t  hcoef,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [23:0]      temp_centi,
  output logic [31:0]      pressure,
  output logic [1:0]       pstat,
  output logic [16:0]      humidity,
  output logic             hum_dis
);

  typedef struct packed {
    logic [23:0] tc;
    logic [23:0] rawp;
    logic [15:0] rawh;
    logic        pdis;
    logic        hdis;
  } side_t;

  typedef struct packed {
    logic [63:0] an;
    logic [63:0] ad;
    logic        neg;
    logic        zero;
  } pdiv_t;

  logic        en;
  logic [8:0]  bv_r;
  logic [5:0]  cv_r;
  side_t       sd_r [9];
  pdiv_t       pd_r [3];

  // Pressure front half.
  logic signed [32:0] v1_r;
  logic [63:0]        vv_r, vvp6_r, vvp3_r, v2_r, w_r, v1c_r, pnum_r, n_r, den_r;
  logic signed [48:0] v1p5_r, v1p2_r, v1p5b_r, v1p2b_r;
  logic signed [65:0] vv_full;
  logic signed [79:0] vvp6_full, vvp3_full;
  logic [63:0]        wp1, v2_nxt, w_nxt;
  logic [20:0]        pbase;

  // Humidity.
  logic [31:0] xh_r, xh6_r, xh3_r, xh5_r, ha_r, ha4_r, ha5_r, hm1_r, hm2_r, hb_r;
  logic [31:0] hab_r, hab7_r, hab8_r, hss_r, hm3_r;
  logic [31:0] hsum, ha1, ha2, hs, hx;
  logic [16:0] hum9_r;
  logic [1:0]  st9_r;

  // Pressure back half.
  logic              dv;
  logic [63:0]       dq;
  esc_pkg::div_tag_t dtag;
  esc_pkg::div_tag_t tag_r [5];
  logic [63:0]       p1c_r, p2c_r, p3c_r, p4c_r, p5c_r;
  logic [63:0]       mll_r, qq_r, p8p_r, p8p3_r, p8p4_r, qqp9_r, s_r;
  logic [31:0]       mlh_r;
  logic [63:0]       q13, rsum;
  logic signed [79:0] p8p_full, qqp9_full;
  logic [31:0]       press_nxt;

  logic [23:0] temp_r;
  logic [31:0] press_r;
  logic [1:0]  pstat_r;
  logic [16:0] hum_r;
  logic        hdis_r;

  assign en  = !cv_r[5] || out_ready;
  assign pop = en && !qstat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= '0;
      cv_r <= '0;
    end else if (en) begin
      bv_r <= {bv_r[7:0], pop};
      cv_r <= {cv_r[4:0], dv};
    end
  end

  always_comb begin
    vv_full   = v1_r * v1_r;
    vvp6_full = $signed(vv_r) * $signed(pcoef.p6);
    vvp3_full = $signed(vv_r) * $signed(pcoef.p3);
    v2_nxt    = vvp6_r + ({{15{v1p5b_r[48]}}, v1p5b_r} << 17)
              + ({{48{pcoef.p4[15]}}, pcoef.p4} << 35);
    w_nxt     = 64'h0000_8000_0000_0000 + 64'($signed(vvp3_r) >>> 8)
              + ({{15{v1p2b_r[48]}}, v1p2b_r} << 12);
    wp1       = w_r * {48'd0, pcoef.p1};
    pbase     = 21'd1048576 - {1'b0, sd_r[3].rawp[23:4]};
    hsum      = {2'b0, sd_r[1].rawh, 14'd0} - {hcoef.h4, 20'd0} - xh5_r + 32'd16384;
    ha1       = 32'($signed(xh6_r) >>> 10);
    ha2       = 32'($signed(xh3_r) >>> 11) + 32'd32768;
    hs        = 32'($signed(hab_r) >>> 15);
    hx        = hab8_r - 32'($signed(hm3_r) >>> 4);
  end

  // Stages before the divider.
  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= '{tc: item.temp_centi, rawp: item.raw_pressure,
                   rawh: item.raw_humidity, pdis: item.press_dis,
                   hdis: item.hum_dis};
      for (int k = 1; k < 9; k++) begin
        sd_r[k] <= sd_r[k-1];
      end
      v1_r    <= $signed({item.fine[31], item.fine}) - 33'sd128000;
      xh_r    <= item.fine - 32'd76800;
      vv_r    <= vv_full[63:0];
      v1p5_r  <= v1_r * $signed(pcoef.p5);
      v1p2_r  <= v1_r * $signed(pcoef.p2);
      xh6_r   <= xh_r * {{24{hcoef.h6[7]}}, hcoef.h6};
      xh3_r   <= xh_r * {24'd0, hcoef.h3};
      xh5_r   <= xh_r * {{20{hcoef.h5[11]}}, hcoef.h5};
      vvp6_r  <= vvp6_full[63:0];
      vvp3_r  <= vvp3_full[63:0];
      v1p5b_r <= v1p5_r;
      v1p2b_r <= v1p2_r;
      ha_r    <= 32'($signed(hsum) >>> 15);
      hm1_r   <= ha1 * ha2;
      v2_r    <= v2_nxt;
      w_r     <= w_nxt;
      ha4_r   <= ha_r;
      hm2_r   <= (32'($signed(hm1_r) >>> 10) + 32'd2097152)
               * {{16{hcoef.h2[15]}}, hcoef.h2};
      v1c_r   <= 64'($signed(wp1) >>> 33);
      pnum_r  <= ({43'd0, pbase} << 31) - v2_r;
      hb_r    <= 32'($signed(hm2_r + 32'd8192) >>> 14);
      ha5_r   <= ha4_r;
      n_r     <= pnum_r * 64'd3125;
      den_r   <= v1c_r;
      hab_r   <= ha5_r * hb_r;
      pd_r[0] <= '{an: n_r[63] ? (64'd0 - n_r) : n_r,
                   ad: (den_r == '0) ? 64'd1 : (den_r[63] ? (64'd0 - den_r) : den_r),
                   neg: n_r[63] ^ den_r[63], zero: (den_r == '0)};
      pd_r[1] <= pd_r[0];
      pd_r[2] <= pd_r[1];
      hss_r   <= hs * hs;
      hab7_r  <= hab_r;
      hm3_r   <= 32'($signed(hss_r) >>> 7) * {24'd0, hcoef.h1};
      hab8_r  <= hab7_r;
      if (sd_r[7].hdis || hx[31]) begin
        hum9_r <= '0;
      end else if (hx > esc_pkg::HUM_MAX) begin
        hum9_r <= esc_pkg::HUM_MAX[28:12];
      end else begin
        hum9_r <= hx[28:12];
      end
      if (sd_r[7].pdis) begin
        st9_r <= esc_pkg::PSTAT_DIS;
      end else if (pd_r[1].zero) begin
        st9_r <= esc_pkg::PSTAT_DIV0;
      end else begin
        st9_r <= esc_pkg::PSTAT_OK;
      end
    end
  end

  esc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (bv_r[8]),
    .dividend (pd_r[2].an),
    .divisor  (pd_r[2].ad),
    .in_tag   ('{q_neg: pd_r[2].neg, status: st9_r, temp_centi: sd_r[8].tc,
                 humidity: hum9_r, hum_dis: sd_r[8].hdis}),
    .out_valid(dv),
    .quotient (dq),
    .out_tag  (dtag)
  );

  always_comb begin
    q13       = 64'($signed(p1c_r) >>> 13);
    p8p_full  = $signed(p1c_r) * $signed(pcoef.p8);
    qqp9_full = $signed(qq_r) * $signed(pcoef.p9);
    rsum      = 64'($signed(s_r) >>> 8) + ({{48{pcoef.p7[15]}}, pcoef.p7} << 4);
    if ($signed(rsum) > 64'sh7FFFFFFF) begin
      press_nxt = 32'h7FFFFFFF;
    end else if ($signed(rsum) < -64'sh80000000) begin
      press_nxt = 32'h80000000;
    end else begin
      press_nxt = rsum[31:0];
    end
  end

  // Stages after the divider; the last one is the output register.
  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0] <= dtag;
      for (int k = 1; k < 5; k++) begin
        tag_r[k] <= tag_r[k-1];
      end
      p1c_r  <= dtag.q_neg ? (64'd0 - dq) : dq;
      mll_r  <= {32'd0, q13[31:0]} * {32'd0, q13[31:0]};
      mlh_r  <= q13[31:0] * q13[63:32];
      p8p_r  <= p8p_full[63:0];
      p2c_r  <= p1c_r;
      qq_r   <= mll_r + {mlh_r[30:0], 33'd0};
      p8p3_r <= p8p_r;
      p3c_r  <= p2c_r;
      qqp9_r <= qqp9_full[63:0];
      p8p4_r <= p8p3_r;
      p4c_r  <= p3c_r;
      s_r    <= p4c_r + 64'($signed(qqp9_r) >>> 25) + 64'($signed(p8p4_r) >>> 19);
      p5c_r  <= p4c_r;
      temp_r  <= tag_r[4].temp_centi;
      press_r <= (tag_r[4].status == esc_pkg::PSTAT_OK) ? press_nxt : '0;
      pstat_r <= tag_r[4].status;
      hum_r   <= tag_r[4].humidity;
      hdis_r  <= tag_r[4].hum_dis;
    end
  end

  assign out_valid  = cv_r[5];
  assign temp_centi = temp_r;
  assign pressure   = press_r;
  assign pstat      = pstat_r;
  assign humidity   = hum_r;
  assign hum_dis    = hdis_r;

endmodule
